// ===== design/hctl_pkg.sv =====
package hctl_pkg;

  localparam int NUM_SYMBOLS_DEF = 256;
  localparam int MAX_CODE_LEN    = 32;
  localparam int LEN_W           = 6;
  localparam int BITS_W          = 32;
  localparam int SYM_PORT_W      = 8;

  typedef struct packed {
    logic                  key_load;   // lookup word accepted
    logic                  wr_en;      // table write word accepted
    logic                  rd_en;
    logic [SYM_PORT_W-1:0] rd_addr;
    logic                  hold_load;
    logic                  hold_found;
    logic                  out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } status_t;

  // keeps the low len bits, all bits from 32 up
  function automatic logic [BITS_W-1:0] low_mask(input logic [LEN_W-1:0] len);
    logic [BITS_W-1:0] m;
    begin
      if (len >= LEN_W'(BITS_W)) begin
        m = '1;
      end else begin
        m = ~({BITS_W{1'b1}} << len);
      end
      return m;
    end
  endfunction

endpackage

// ===== design/hctl_ctrl.sv =====
module hctl_ctrl #(
  parameter int NUM_SYMBOLS = hctl_pkg::NUM_SYMBOLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             func,
  output logic             out_valid,
  input  logic             out_ready,
  input  hctl_pkg::status_t status,
  output hctl_pkg::cmd_t    cmd
);

  localparam int SYM_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]       state, state_next;
  logic [SYM_W-1:0] cnt, cnt_next;
  logic             cmp_vld;
  logic             out_valid_next;
  logic             accept;
  logic             out_free;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.rd_addr    = hctl_pkg::SYM_PORT_W'(cnt);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (func) begin
            cmd.key_load = 1'b1;
            cnt_next     = '0;
            state_next   = ST_SCAN;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cmp_vld && status.hit) begin
          cmd.hold_load  = 1'b1;
          cmd.hold_found = 1'b1;
          state_next     = ST_RESULT;
        end else if (cnt == SYM_W'(NUM_SYMBOLS - 1)) begin
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        // last entry read comes back here
        cmd.hold_load  = 1'b1;
        cmd.hold_found = status.hit;
        state_next     = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      cmp_vld   <= (state == ST_SCAN);
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== design/hctl_dp.sv =====
module hctl_dp #(
  parameter int NUM_SYMBOLS = hctl_pkg::NUM_SYMBOLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [hctl_pkg::SYM_PORT_W-1:0]     symbol,
  input  logic [hctl_pkg::LEN_W-1:0]          code_length,
  input  logic [hctl_pkg::BITS_W-1:0]         code_bits,
  input  hctl_pkg::cmd_t                      cmd,
  output hctl_pkg::status_t                   status,
  output logic                                found,
  output logic [hctl_pkg::SYM_PORT_W-1:0]     match_symbol
);

  localparam int SYM_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int ENTRY_W = hctl_pkg::LEN_W + hctl_pkg::BITS_W;

  logic [ENTRY_W-1:0]              mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0]          entry_vld;
  logic [ENTRY_W-1:0]              rd_data;
  logic                            rd_vld;
  logic [SYM_W-1:0]                rd_idx;
  logic [hctl_pkg::LEN_W-1:0]      key_len;
  logic [hctl_pkg::BITS_W-1:0]     key_bits;
  logic [hctl_pkg::BITS_W-1:0]     key_mask;
  logic                            hold_found;
  logic [SYM_W-1:0]                hold_sym;
  logic                            wr_ok;
  logic [SYM_W-1:0]                wr_addr;
  logic [SYM_W-1:0]                rd_addr;
  logic [hctl_pkg::LEN_W-1:0]      entry_len;
  logic [hctl_pkg::BITS_W-1:0]     entry_bits;

  assign wr_addr = symbol[SYM_W-1:0];
  assign rd_addr = cmd.rd_addr[SYM_W-1:0];
  assign wr_ok   = cmd.wr_en
                && ({1'b0, symbol} < 9'(NUM_SYMBOLS))
                && ({1'b0, code_length} <= 7'(hctl_pkg::MAX_CODE_LEN));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= {code_length, code_bits & hctl_pkg::low_mask(code_length)};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // entries never written read as length zero
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else if (wr_ok) begin
      entry_vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_vld <= entry_vld[rd_addr];
      rd_idx <= rd_addr;
    end
    if (cmd.key_load) begin
      key_len  <= code_length;
      key_bits <= code_bits;
      key_mask <= hctl_pkg::low_mask(code_length);
    end
    if (cmd.hold_load) begin
      hold_found <= cmd.hold_found;
      hold_sym   <= cmd.hold_found ? rd_idx : '0;
    end
    if (cmd.out_load) begin
      found        <= hold_found;
      match_symbol <= hctl_pkg::SYM_PORT_W'(hold_sym);
    end
  end

  assign entry_len  = rd_vld ? rd_data[ENTRY_W-1:hctl_pkg::BITS_W] : '0;
  assign entry_bits = rd_data[hctl_pkg::BITS_W-1:0];
  assign status.hit = (entry_len == key_len)
                   && (((entry_bits ^ key_bits) & key_mask) == '0);

endmodule

// ===== design/huffman_code_table_lookup.sv =====
// huffman code table lookup
// input channel (in_valid/in_ready) carries one word: func, symbol, code_length,
// code_bits. func 0 writes the entry of one symbol and gives no result; func 1
// looks up a code and gives one result word (found, match_symbol) on the output
// channel (out_valid/out_ready).
// after a write the block stays idle and is ready again in the next cycle.
// a lookup scans the table in symbol order through one registered read port,
// one entry per cycle, and stops at the first match: a hit goes from the scan
// to the result state, a miss passes through a drain state for the last entry.
// no new word is taken during the scan; in_ready rises with out_valid, so a
// new lookup is taken only after the result of the last one has been issued.
// a finished result moves to the output register once that register is free;
// while the receiver stalls the block keeps taking words, but the result of a
// following lookup then waits in a holding register with in_ready low until
// the earlier word has been taken
// reset clears every code length to zero at once (per-entry valid flags),
// so the block is ready as soon as reset is released; code bits of an
// entry are undefined until it is written.
module huffman_code_table_lookup #(
  parameter int NUM_SYMBOLS = hctl_pkg::NUM_SYMBOLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic [hctl_pkg::SYM_PORT_W-1:0]   symbol,
  input  logic [hctl_pkg::LEN_W-1:0]        code_length,
  input  logic [hctl_pkg::BITS_W-1:0]       code_bits,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic [hctl_pkg::SYM_PORT_W-1:0]   match_symbol
);

  hctl_pkg::cmd_t    cmd;
  hctl_pkg::status_t status;

  hctl_ctrl #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  hctl_dp #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .symbol       (symbol),
    .code_length  (code_length),
    .code_bits    (code_bits),
    .cmd          (cmd),
    .status       (status),
    .found        (found),
    .match_symbol (match_symbol)
  );

endmodule
